/* src/efi_pkg.sv */
package efi_pkg;

  // Field widths
  localparam int COMP_W    = 32;
  localparam int FRAC_BITS = 28;
  localparam int CNT_W     = 16;
  localparam int MAG_W     = 35;
  localparam int PROD_W    = 2 * COMP_W;

  // Width of |z|^2 before saturation: two truncated squares plus a carry
  localparam int MAG_FULL_W = PROD_W - FRAC_BITS + 1;

  // Widths of the update sums: shifted product plus sign-extended constant
  localparam int RE_SUM_W = PROD_W - FRAC_BITS + 1;
  localparam int IM_SUM_W = PROD_W - FRAC_BITS + 2;

  // Escape radius squared, 4.0 in the fixed-point format
  localparam logic [MAG_FULL_W-1:0] FOUR = MAG_FULL_W'(4) << FRAC_BITS;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(256);

  // Input point transaction
  typedef struct packed {
    logic signed [COMP_W-1:0] start_re;
    logic signed [COMP_W-1:0] start_im;
    logic signed [COMP_W-1:0] const_re;
    logic signed [COMP_W-1:0] const_im;
  } pt_t;

  // Result transaction
  typedef struct packed {
    logic        [CNT_W-1:0]  escape_count;
    logic signed [COMP_W-1:0] final_re;
    logic signed [COMP_W-1:0] final_im;
    logic        [MAG_W-1:0]  final_mag_sq;
  } res_t;

endpackage

/* src/escape_time_fractal_iterator_top.sv */
// Channel  Direction  Handshake          Payload
// pt       in         pt_valid/pt_stall  pt_data  (efi_pkg::pt_t: z0 and c)
// res      out        res_valid/res_stall res_data (efi_pkg::res_t)
// cfg      in         cfg_valid/cfg_ready cfg_data (iteration_limit)
//
// From acceptance to a loaded result, each square-add step of a point is
// three passes through the one shared 32x32 multiplier plus an update
// state. A new point is taken in the cycle after the result is loaded
// into the output register.
// Reset (rst, synchronous) returns the sequencer to idle and the limit to 256.
// A stalled result holds the output register; the sequencer waits to load it.
module escape_time_fractal_iterator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pt_valid,
  output logic                             pt_stall,
  input  efi_pkg::pt_t                     pt_data,
  output logic                             res_valid,
  input  logic                             res_stall,
  output efi_pkg::res_t                    res_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [efi_pkg::CNT_W-1:0]        cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RR   = 3'd1;
  localparam logic [2:0] S_II   = 3'd2;
  localparam logic [2:0] S_RI   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [efi_pkg::CNT_W-1:0] limit;
  logic [efi_pkg::CNT_W-1:0] count;
  logic signed [efi_pkg::COMP_W-1:0] re;
  logic signed [efi_pkg::COMP_W-1:0] im;
  logic signed [efi_pkg::COMP_W-1:0] cre;
  logic signed [efi_pkg::COMP_W-1:0] cim;
  logic signed [efi_pkg::PROD_W-1:0] rr;
  logic signed [efi_pkg::PROD_W-1:0] diff;
  logic [efi_pkg::MAG_W-1:0] mag;

  logic signed [efi_pkg::COMP_W-1:0] mul_a;
  logic signed [efi_pkg::COMP_W-1:0] mul_b;
  logic signed [efi_pkg::PROD_W-1:0] product;
  logic signed [efi_pkg::COMP_W-1:0] nre;
  logic signed [efi_pkg::COMP_W-1:0] nim;
  logic [efi_pkg::MAG_FULL_W-1:0] mag_full;
  logic [efi_pkg::MAG_W-1:0] mag_sat;
  logic stop;
  logic res_load;

  assign cfg_ready = 1'b1;
  assign pt_stall  = (state != S_IDLE);
  assign res_load  = (state == S_DONE) && (!res_valid || !res_stall);

  // Select multiplier operands for the current pass
  always_comb begin
    unique case (state)
      S_RR:    begin mul_a = re; mul_b = re; end
      S_II:    begin mul_a = im; mul_b = im; end
      default: begin mul_a = re; mul_b = im; end
    endcase
  end

  efi_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  efi_upd u_upd (
    .diff (diff),
    .prod (product),
    .cre  (cre),
    .cim  (cim),
    .nre  (nre),
    .nim  (nim)
  );

  // Sum the truncated squares; in S_RI the product holds im*im
  always_comb begin
    mag_full = {1'b0, rr[efi_pkg::PROD_W-1:efi_pkg::FRAC_BITS]}
             + {1'b0, product[efi_pkg::PROD_W-1:efi_pkg::FRAC_BITS]};
    mag_sat  = (|mag_full[efi_pkg::MAG_FULL_W-1:efi_pkg::MAG_W]) ? efi_pkg::MAG_MAX
             : mag_full[efi_pkg::MAG_W-1:0];
    stop     = (mag_full >= efi_pkg::FOUR) || (count >= limit);
  end

  // Hold the iteration limit
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= efi_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // Sequence the multiplier passes and the update
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (pt_valid) state <= S_RR;
        S_RR:    state <= S_II;
        S_II:    state <= S_RI;
        S_RI:    state <= stop ? S_DONE : S_UPD;
        S_UPD:   state <= S_RR;
        S_DONE:  if (res_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        re    <= pt_data.start_re;
        im    <= pt_data.start_im;
        cre   <= pt_data.const_re;
        cim   <= pt_data.const_im;
        count <= efi_pkg::CNT_W'(1);
      end
      S_II: rr <= product;
      S_RI: begin
        diff <= rr - product;
        mag  <= mag_sat;
      end
      S_UPD: begin
        re    <= nre;
        im    <= nim;
        count <= count + efi_pkg::CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Drop the result valid once taken, load a finished result
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data.escape_count <= count - efi_pkg::CNT_W'(1);
      res_data.final_re     <= re;
      res_data.final_im     <= im;
      res_data.final_mag_sq <= mag;
    end
  end

endmodule

/* src/efi_mul.sv */
module efi_mul (
  input  logic                              clk,
  input  logic signed [efi_pkg::COMP_W-1:0] a,
  input  logic signed [efi_pkg::COMP_W-1:0] b,
  output logic signed [efi_pkg::PROD_W-1:0] product
);

  // Register the full-precision signed product
  always_ff @(posedge clk) begin
    product <= a * b;
  end

endmodule

/* src/efi_upd.sv */
module efi_upd (
  input  logic signed [efi_pkg::PROD_W-1:0] diff,
  input  logic signed [efi_pkg::PROD_W-1:0] prod,
  input  logic signed [efi_pkg::COMP_W-1:0] cre,
  input  logic signed [efi_pkg::COMP_W-1:0] cim,
  output logic signed [efi_pkg::COMP_W-1:0] nre,
  output logic signed [efi_pkg::COMP_W-1:0] nim
);

  logic signed [efi_pkg::RE_SUM_W-1:0] re_sum;
  logic signed [efi_pkg::IM_SUM_W-1:0] im_sum;
  logic [efi_pkg::RE_SUM_W-efi_pkg::COMP_W:0] re_hi;
  logic [efi_pkg::IM_SUM_W-efi_pkg::COMP_W:0] im_hi;

  // Floor-shift the products (arithmetic shift) and add the constant
  always_comb begin
    re_sum = $signed({diff[efi_pkg::PROD_W-1], diff[efi_pkg::PROD_W-1:efi_pkg::FRAC_BITS]})
           + efi_pkg::RE_SUM_W'(cre);
    im_sum = $signed({prod[efi_pkg::PROD_W-1], prod[efi_pkg::PROD_W-1:efi_pkg::FRAC_BITS-1]})
           + efi_pkg::IM_SUM_W'(cim);
  end

  // Saturate each component to the signed component range
  always_comb begin
    re_hi = re_sum[efi_pkg::RE_SUM_W-1:efi_pkg::COMP_W-1];
    im_hi = im_sum[efi_pkg::IM_SUM_W-1:efi_pkg::COMP_W-1];
    if (&re_hi || !(|re_hi)) begin
      nre = re_sum[efi_pkg::COMP_W-1:0];
    end else begin
      nre = re_sum[efi_pkg::RE_SUM_W-1] ? efi_pkg::COMP_MIN : efi_pkg::COMP_MAX;
    end
    if (&im_hi || !(|im_hi)) begin
      nim = im_sum[efi_pkg::COMP_W-1:0];
    end else begin
      nim = im_sum[efi_pkg::IM_SUM_W-1] ? efi_pkg::COMP_MIN : efi_pkg::COMP_MAX;
    end
  end

endmodule

/* verif/tb_escape_time_fractal_iterator_top.sv */
module tb_escape_time_fractal_iterator_top;
  import efi_pkg::*;

  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam int TAIL_CYCLES = 64;

  // Predicts each orbit and holds the results still owed by the block
  class orbit_ledger;
    logic [CNT_W-1:0] limit;
    res_t pending[$];
    int unsigned mismatches;

    function new();
      limit = LIMIT_RESET;
      mismatches = 0;
    endfunction

    // Sum of the two separately truncated squares
    function longint unsigned square_sum(longint signed a, longint signed b);
      return ((a * a) >>> FRAC_BITS) + ((b * b) >>> FRAC_BITS);
    endfunction

    function longint signed clamp_comp(longint signed v);
      if (v > longint'(COMP_MAX)) return longint'(COMP_MAX);
      if (v < longint'(COMP_MIN)) return longint'(COMP_MIN);
      return v;
    endfunction

    // Iterate z = z^2 + c until escape or the step limit
    function res_t run_orbit(pt_t p);
      longint signed zr, zi, cr, ci, nr, ni;
      longint unsigned mag, four_q;
      int unsigned steps;
      res_t r;
      zr = p.start_re;
      zi = p.start_im;
      cr = p.const_re;
      ci = p.const_im;
      four_q = 64'd4 << FRAC_BITS;
      steps = 1;
      mag = square_sum(zr, zi);
      while (mag < four_q && steps < limit) begin
        nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
        ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
        zr = clamp_comp(nr);
        zi = clamp_comp(ni);
        mag = square_sum(zr, zi);
        steps++;
      end
      r.escape_count = CNT_W'(steps - 1);
      r.final_re = zr[COMP_W-1:0];
      r.final_im = zi[COMP_W-1:0];
      r.final_mag_sq = (mag > longint'(MAG_MAX)) ? MAG_MAX : mag[MAG_W-1:0];
      return r;
    endfunction

    function void log_point(pt_t p);
      pending.push_back(run_orbit(p));
    endfunction

    // Compare one result transaction with the oldest prediction
    function void match_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result count %0d re %h im %h mag %h", $time,
                 got.escape_count, got.final_re, got.final_im, got.final_mag_sq);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.escape_count !== want.escape_count) begin
        $display("%0t: escape_count expected %0d got %0d", $time,
                 want.escape_count, got.escape_count);
        mismatches++;
      end
      if (got.final_re !== want.final_re) begin
        $display("%0t: final_re expected %h got %h", $time, want.final_re, got.final_re);
        mismatches++;
      end
      if (got.final_im !== want.final_im) begin
        $display("%0t: final_im expected %h got %h", $time, want.final_im, got.final_im);
        mismatches++;
      end
      if (got.final_mag_sq !== want.final_mag_sq) begin
        $display("%0t: final_mag_sq expected %h got %h", $time,
                 want.final_mag_sq, got.final_mag_sq);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pt_valid = 1'b0;
  logic pt_stall;
  pt_t pt_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  orbit_ledger ledger = new();
  bit calm = 1'b0;
  int stall_left = 0;
  longint cycles = 0;

  escape_time_fractal_iterator_top uut (
    .clk(clk),
    .rst(rst),
    .pt_valid(pt_valid),
    .pt_stall(pt_stall),
    .pt_data(pt_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic int to_q(real v);
    return int'(v * real'(ONE_Q));
  endfunction

  function automatic pt_t mk_pt(int zr, int zi, int cr, int ci);
    pt_t p;
    p.start_re = zr;
    p.start_im = zi;
    p.const_re = cr;
    p.const_im = ci;
    return p;
  endfunction

  function automatic int edge_comp();
    case ($urandom_range(0, 5))
      0: return COMP_MIN;
      1: return COMP_MAX;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed Mandelbrot and Julia points, the rest raw or extreme
  function automatic pt_t rand_point();
    int unsigned sel;
    int small_re, small_im;
    sel = $urandom_range(0, 99);
    small_re = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255)) - 128 : 0;
    small_im = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255)) - 128 : 0;
    if (sel < 45)
      return mk_pt(small_re, small_im,
                   int'($urandom_range(0, 5 * ONE_Q / 2)) - 2 * ONE_Q,
                   int'($urandom_range(0, 5 * ONE_Q / 2)) - 5 * ONE_Q / 4);
    if (sel < 70)
      return mk_pt(int'($urandom_range(0, 4 * ONE_Q - 1)) - 2 * ONE_Q,
                   int'($urandom_range(0, 4 * ONE_Q - 1)) - 2 * ONE_Q,
                   int'($urandom_range(0, 2 * ONE_Q - 1)) - ONE_Q,
                   int'($urandom_range(0, 2 * ONE_Q - 1)) - ONE_Q);
    if (sel < 85)
      return mk_pt($urandom, $urandom, $urandom, $urandom);
    return mk_pt(edge_comp(), edge_comp(), edge_comp(), edge_comp());
  endfunction

  // Offer one point, hold it until accepted, then maybe drop valid for a gap
  task automatic send_point(pt_t p);
    int gap;
    pt_data <= p;
    pt_valid <= 1'b1;
    do @(posedge clk); while (!(pt_valid && !pt_stall));
    ledger.log_point(p);
    gap = pick_gap();
    if (gap > 0) begin
      pt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_drained();
    pt_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending.size() != 0);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    ledger.limit = v;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] lim, int n);
    wait_drained();
    write_limit(lim);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
      send_point(rand_point());
      if ($urandom_range(0, 59) == 0) wait_drained();
    end
  endtask

  // Check result transactions and drive a random stall pattern
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) ledger.match_result(res_data);
    if (stall_left == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_escape_time_fractal_iterator_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed points at the reset limit
    send_point(mk_pt(0, 0, 0, 0));
    send_point(mk_pt(0, 0, to_q(-2.0), 0));
    send_point(mk_pt(0, 0, to_q(0.25), 0));
    send_point(mk_pt(COMP_MIN, COMP_MIN, 0, 0));
    send_point(mk_pt(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_point(mk_pt(0, 0, COMP_MIN, COMP_MIN));
    send_point(mk_pt(to_q(1.9), 0, COMP_MAX, 0));
    send_point(mk_pt(0, to_q(1.9), COMP_MIN, 0));
    send_point(mk_pt(to_q(1.4), to_q(1.4), 0, COMP_MAX));
    send_point(mk_pt(to_q(1.4), to_q(-1.4), 0, COMP_MIN));
    send_point(mk_pt(0, 3, 0, 0));
    send_point(mk_pt(-3, 5, 0, 0));
    send_point(mk_pt(to_q(1.0), 0, 0, 0));
    send_point(mk_pt(to_q(2.0), 0, 0, 0));
    send_point(mk_pt(to_q(2.0) - 1, 0, 0, 0));
    send_point(mk_pt(to_q(0.3), to_q(-0.5), to_q(-0.8), to_q(0.156)));
    send_point(mk_pt(-1, -1, -1, -1));

    // Limits of zero and one take no step
    run_phase(16'd0, 20);
    run_phase(16'd1, 20);

    // Largest limit: one full-length orbit, one that escapes and one random point
    wait_drained();
    write_limit(16'hFFFF);
    send_point(mk_pt(0, 0, 0, 0));
    send_point(mk_pt(0, 0, to_q(-0.75), to_q(0.1)));
    send_point(mk_pt($urandom, $urandom, $urandom, $urandom));

    run_phase(16'd2, 100);
    run_phase(16'd3, 100);
    run_phase(16'd16, 100);
    run_phase(16'd32, 100);
    run_phase(16'd64, 100);
    run_phase(CNT_W'($urandom_range(5, 120)), 100);
    run_phase(16'd256, 100);
    run_phase(16'd128, 100);
    run_phase(16'd48, 100);

    // Drain, then watch a little longer for stray results
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("tb_escape_time_fractal_iterator_top: clean");
    end else begin
      $display("tb_escape_time_fractal_iterator_top: errors");
    end
    $finish;
  end

endmodule

/* escape_time_fractal_iterator_top.f */
src/efi_pkg.sv
src/efi_mul.sv
src/efi_upd.sv
src/escape_time_fractal_iterator_top.sv
verif/tb_escape_time_fractal_iterator_top.sv
